// ===== rtl/asgr_pkg.sv =====
// Shared constants, types and the colour function of the SGR stream parser.
package asgr_pkg;

   localparam int MaxParams = 16;
   localparam int IdxW = $clog2(MaxParams);
   localparam int CntW = $clog2(MaxParams + 1);

   localparam logic [15:0] EscCode = 16'h001b;
   localparam logic [15:0] FinalLo = 16'h0040;
   localparam logic [15:0] FinalHi = 16'h007e;
   localparam logic [15:0] SemiCode = 16'h003b;
   localparam logic [15:0] BrktCode = 16'h005b;
   localparam logic [15:0] MCode = 16'h006d;
   localparam logic [15:0] ZeroCode = 16'h0030;
   localparam logic [15:0] NineCode = 16'h0039;
   localparam logic [9:0] SatLimit = 10'd1023;

   // Stored part: bit 11 invalid, bit 10 empty, bits 9..0 value.
   typedef logic [11:0] part_type;

   typedef struct packed {
      logic       start;     // open a CSI sequence
      logic       digit;     // fold a digit into the current part
      logic       bad;       // mark the current part invalid
      logic       push;      // store the current part
      logic       walk_init; // reset the walk index
      logic       walk_step; // apply the entry under the walk index
      logic       load_out;  // capture a result
   } cmd_type;

   typedef struct packed {
      logic walk_done;
   } sts_type;

   localparam logic [23:0] BaseColors [16] = '{
      24'h000000, 24'hcd3131, 24'h0dbc79, 24'he5e510,
      24'h2472c8, 24'hbc3fbc, 24'h11a8cd, 24'he5e5e5,
      24'h666666, 24'hf14c4c, 24'h23d18b, 24'hf5f543,
      24'h3b8eea, 24'hd670d6, 24'h29b8db, 24'hffffff};

   localparam logic [7:0] CubeLevels [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

   function automatic logic [23:0] color256(input logic [7:0] idx);
      logic [7:0] c;
      logic [7:0] rem;
      logic [7:0] g;
      logic [2:0] r6;
      logic [2:0] g6;
      logic [2:0] b6;
      c = idx - 8'd16;
      r6 = (c >= 8'd180) ? 3'd5 : (c >= 8'd144) ? 3'd4 : (c >= 8'd108) ? 3'd3 :
           (c >= 8'd72) ? 3'd2 : (c >= 8'd36) ? 3'd1 : 3'd0;
      rem = c - {5'd0, r6} * 8'd36;
      g6 = (rem >= 8'd30) ? 3'd5 : (rem >= 8'd24) ? 3'd4 : (rem >= 8'd18) ? 3'd3 :
           (rem >= 8'd12) ? 3'd2 : (rem >= 8'd6) ? 3'd1 : 3'd0;
      b6 = 3'(rem - {5'd0, g6} * 8'd6);
      g = 8'd8 + (idx - 8'd232) * 8'd10;
      if (idx < 8'd16) begin
         color256 = BaseColors[idx[3:0]];
      end else if (idx < 8'd232) begin
         color256 = {CubeLevels[r6], CubeLevels[g6], CubeLevels[b6]};
      end else begin
         color256 = {g, g, g};
      end
   endfunction

endpackage

// ===== rtl/asgr_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
module asgr_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/asgr_ctrl.sv =====
// Controller state machine of the SGR stream parser.
module asgr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [15:0]        req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output asgr_pkg::cmd_type  cmd,
   input  asgr_pkg::sts_type  sts
);
   typedef enum logic [2:0] {GROUND, AFTER_ESC, IN_CSI, WALK_WAIT, WALK} state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      acc;
   logic      out_free;
   logic      is_final;

   assign out_free = !valid_ff || rsp_tready;
   assign req_tready = out_free && (state_ff == GROUND || state_ff == AFTER_ESC ||
                                    state_ff == IN_CSI);
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;
   assign is_final = req_tdata >= asgr_pkg::FinalLo && req_tdata <= asgr_pkg::FinalHi;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      case (state_ff)
         GROUND, AFTER_ESC: begin
            if (acc) begin
               if (req_tdata == asgr_pkg::EscCode) begin
                  state_in = AFTER_ESC;
               end else if (state_ff == AFTER_ESC && req_tdata == asgr_pkg::BrktCode) begin
                  state_in = IN_CSI;
                  cmd.start = 1'b1;
               end else begin
                  state_in = GROUND;
                  cmd.load_out = 1'b1;
                  valid_in = 1'b1;
               end
            end
         end
         IN_CSI: begin
            if (acc) begin
               if (is_final) begin
                  cmd.push = 1'b1;
                  if (req_tdata == asgr_pkg::MCode) begin
                     cmd.walk_init = 1'b1;
                     state_in = WALK_WAIT;
                  end else begin
                     state_in = GROUND;
                  end
               end else if (req_tdata == asgr_pkg::SemiCode) begin
                  cmd.push = 1'b1;
               end else if (req_tdata >= asgr_pkg::ZeroCode &&
                            req_tdata <= asgr_pkg::NineCode) begin
                  cmd.digit = 1'b1;
               end else begin
                  cmd.bad = 1'b1;
               end
            end
         end
         WALK_WAIT: begin
            state_in = WALK;
         end
         WALK: begin
            if (sts.walk_done) begin
               state_in = GROUND;
            end else begin
               cmd.walk_step = 1'b1;
               state_in = WALK_WAIT;
            end
         end
         default: state_in = GROUND;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GROUND;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule

// ===== rtl/asgr_dp.sv =====
// Datapath of the SGR stream parser: part accumulator, parameter store and attributes.
module asgr_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        req_tdata,
   input  asgr_pkg::cmd_type  cmd,
   output asgr_pkg::sts_type  sts,
   output logic [71:0]        rsp_tdata
);
   localparam int IdxW = asgr_pkg::IdxW;
   localparam int CntW = asgr_pkg::CntW;
   localparam int WalkW = CntW + 1;

   asgr_pkg::part_type accum_ff, accum_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [WalkW-1:0]   idx_ff, idx_in;
   logic [1:0]         ext_ff, ext_in;   // 0 none, 1 expect mode, 2 mode 5, 3 mode 2
   logic               ext_fg_ff, ext_fg_in;
   logic [1:0]         rgb_n_ff, rgb_n_in;
   logic [7:0]         r_ff, r_in, g_ff, g_in;
   logic               rgb_ok_ff, rgb_ok_in;
   logic               bold_ff, bold_in, ital_ff, ital_in, und_ff, und_in;
   logic               fga_ff, fga_in, bga_ff, bga_in;
   logic [23:0]        fg_ff, fg_in, bg_ff, bg_in;
   logic [71:0]        out_ff;

   asgr_pkg::part_type rd_data;
   logic [IdxW-1:0]    rd_addr;
   logic               wr_en;
   logic [13:0]        prod;
   logic [9:0]         base;
   logic [WalkW-1:0]   cnt_w;
   logic               p_ok;
   logic [9:0]         pv;
   logic [9:0]         code;
   logic               byte_ok;

   assign wr_en = cmd.push && count_ff < CntW'(asgr_pkg::MaxParams);
   assign rd_addr = idx_in[IdxW-1:0];
   assign cnt_w = WalkW'(count_ff);

   asgr_ram #(.Width(12), .Depth(asgr_pkg::MaxParams)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[IdxW-1:0]), .wr_data(accum_ff),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign sts.walk_done = idx_ff >= cnt_w;
   assign base = accum_ff[10] ? 10'd0 : accum_ff[9:0];
   assign prod = {1'b0, base, 3'b000} + {3'b000, base, 1'b0} + 14'(req_tdata[3:0]);
   assign p_ok = rd_data[11:10] == 2'b00;
   assign pv = rd_data[9:0];
   assign code = rd_data[10] ? 10'd0 : pv;
   assign byte_ok = p_ok && pv <= 10'd255;

   always_comb begin
      accum_in = accum_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      ext_in = ext_ff;
      ext_fg_in = ext_fg_ff;
      rgb_n_in = rgb_n_ff;
      r_in = r_ff;
      g_in = g_ff;
      rgb_ok_in = rgb_ok_ff;
      bold_in = bold_ff; ital_in = ital_ff; und_in = und_ff;
      fga_in = fga_ff; bga_in = bga_ff; fg_in = fg_ff; bg_in = bg_ff;
      if (cmd.start) begin
         count_in = '0;
         accum_in = 12'h400;
      end
      if (cmd.digit) begin
         accum_in = {accum_ff[11], 1'b0,
                     (prod > 14'(asgr_pkg::SatLimit)) ? asgr_pkg::SatLimit : prod[9:0]};
      end
      if (cmd.bad) begin
         accum_in = {1'b1, 1'b0, accum_ff[9:0]};
      end
      if (cmd.push) begin
         if (wr_en) count_in = count_ff + 1'b1;
         accum_in = 12'h400;
      end
      if (cmd.walk_init) begin
         idx_in = '0;
         ext_in = 2'd0;
      end
      if (cmd.walk_step) begin
         idx_in = idx_ff + 1'b1;
         case (ext_ff)
            2'd1: begin
               ext_in = 2'd0;
               if (p_ok && pv == 10'd5 && idx_ff + 1'b1 < cnt_w) begin
                  ext_in = 2'd2;
               end else if (p_ok && pv == 10'd2 && idx_ff + 2'd3 < cnt_w) begin
                  ext_in = 2'd3;
                  rgb_n_in = 2'd0;
                  rgb_ok_in = 1'b1;
               end
            end
            2'd2: begin
               ext_in = 2'd0;
               if (byte_ok) begin
                  if (ext_fg_ff) begin
                     fga_in = 1'b1; fg_in = asgr_pkg::color256(pv[7:0]);
                  end else begin
                     bga_in = 1'b1; bg_in = asgr_pkg::color256(pv[7:0]);
                  end
               end
            end
            2'd3: begin
               rgb_ok_in = rgb_ok_ff && byte_ok;
               rgb_n_in = rgb_n_ff + 1'b1;
               if (rgb_n_ff == 2'd0) r_in = pv[7:0];
               if (rgb_n_ff == 2'd1) g_in = pv[7:0];
               if (rgb_n_ff == 2'd2) begin
                  ext_in = 2'd0;
                  if (rgb_ok_ff && byte_ok) begin
                     if (ext_fg_ff) begin
                        fga_in = 1'b1; fg_in = {r_ff, g_ff, pv[7:0]};
                     end else begin
                        bga_in = 1'b1; bg_in = {r_ff, g_ff, pv[7:0]};
                     end
                  end
               end
            end
            default: begin
               if (!rd_data[11]) begin
                  if (code == 10'd0) begin
                     bold_in = 1'b0; ital_in = 1'b0; und_in = 1'b0;
                     fga_in = 1'b0; bga_in = 1'b0; fg_in = '0; bg_in = '0;
                  end else if (code == 10'd1) bold_in = 1'b1;
                  else if (code == 10'd3) ital_in = 1'b1;
                  else if (code == 10'd4) und_in = 1'b1;
                  else if (code == 10'd22) bold_in = 1'b0;
                  else if (code == 10'd23) ital_in = 1'b0;
                  else if (code == 10'd24) und_in = 1'b0;
                  else if (code >= 10'd30 && code <= 10'd37) begin
                     fga_in = 1'b1; fg_in = asgr_pkg::BaseColors[4'(code - 10'd30)];
                  end else if (code == 10'd39) begin
                     fga_in = 1'b0; fg_in = '0;
                  end else if (code >= 10'd40 && code <= 10'd47) begin
                     bga_in = 1'b1; bg_in = asgr_pkg::BaseColors[4'(code - 10'd40)];
                  end else if (code == 10'd49) begin
                     bga_in = 1'b0; bg_in = '0;
                  end else if (code >= 10'd90 && code <= 10'd97) begin
                     fga_in = 1'b1; fg_in = asgr_pkg::BaseColors[4'(code - 10'd82)];
                  end else if (code >= 10'd100 && code <= 10'd107) begin
                     bga_in = 1'b1; bg_in = asgr_pkg::BaseColors[4'(code - 10'd92)];
                  end else if ((code == 10'd38 || code == 10'd48) &&
                               idx_ff + 1'b1 < cnt_w) begin
                     ext_in = 2'd1;
                     ext_fg_in = code == 10'd38;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= 12'h400;
         count_ff <= '0;
         idx_ff <= '0;
         ext_ff <= 2'd0;
         bold_ff <= 1'b0; ital_ff <= 1'b0; und_ff <= 1'b0;
         fga_ff <= 1'b0; bga_ff <= 1'b0; fg_ff <= '0; bg_ff <= '0;
      end else begin
         accum_ff <= accum_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         ext_ff <= ext_in;
         bold_ff <= bold_in; ital_ff <= ital_in; und_ff <= und_in;
         fga_ff <= fga_in; bga_ff <= bga_in; fg_ff <= fg_in; bg_ff <= bg_in;
      end
      ext_fg_ff <= ext_fg_in;
      rgb_n_ff <= rgb_n_in;
      r_ff <= r_in;
      g_ff <= g_in;
      rgb_ok_ff <= rgb_ok_in;
      if (cmd.load_out) begin
         out_ff <= {3'd0,
                    bga_ff ? {bg_ff[7:0], bg_ff[15:8], bg_ff[23:16]} : 24'd0, bga_ff,
                    fga_ff ? {fg_ff[7:0], fg_ff[15:8], fg_ff[23:16]} : 24'd0, fga_ff,
                    und_ff, ital_ff, bold_ff, req_tdata};
      end
   end

   assign rsp_tdata = out_ff;
endmodule

// ===== rtl/ansi_sgr_stream_parser.sv =====
// Top level of the ANSI CSI/SGR stream parser.
//  channel | direction | content
//  req     | in        | tdata[15:0] char_code
//  rsp     | out       | tdata[68:0] text_char, bold, italic, underline, fg set/rgb, bg set/rgb
// A plain character goes to a result register that parts the two sides.
// A final 'm' stalls input while the store is walked
// through its single registered read port.
// Reset is synchronous and clears the mode, attributes and colours.
module ansi_sgr_stream_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,  // char_code[15:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // text_char[15:0], bold[16], italic[17], underline[18], fg_set[19], fg_red[27:20],
   // fg_green[35:28], fg_blue[43:36], bg_set[44], bg_red[52:45], bg_green[60:53],
   // bg_blue[68:61], zero fill above
   output logic [71:0]  rsp_tdata
);
   asgr_pkg::cmd_type cmd;
   asgr_pkg::sts_type sts;

   asgr_ctrl u_ctrl (.clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .cmd(cmd), .sts(sts));

   asgr_dp u_dp (.clock(clock), .reset(reset), .req_tdata(req_tdata), .cmd(cmd),
      .sts(sts), .rsp_tdata(rsp_tdata));

`ifndef SYNTHESIS
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result lost");
   a_walk_block: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> !req_tready) else $error("input taken during walk");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.digit, cmd.bad, cmd.push})) else $error("command clash");
`endif
endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the ANSI SGR stream parser, with its own attribute predictor.
module tb;

   typedef struct packed {
      logic [15:0] ch;
      logic        bold;
      logic        italic;
      logic        uline;
      logic        fg_on;
      logic [7:0]  fg_r;
      logic [7:0]  fg_g;
      logic [7:0]  fg_b;
      logic        bg_on;
      logic [7:0]  bg_r;
      logic [7:0]  bg_g;
      logic [7:0]  bg_b;
   } cell_attr_type;

   typedef struct {
      logic [15:0]   code;
      bit            typed;
      cell_attr_type want;
   } dir_row_type;

   typedef enum logic [1:0] {PM_GROUND, PM_ESC, PM_CSI} pmode_type;

   localparam logic [11:0] EmptyBit = 12'h400;
   localparam logic [11:0] BadBit = 12'h800;
   localparam int CycleLimit = 400000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [15:0]   req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [71:0]   rsp_tdata;

   ansi_sgr_stream_parser u_top (.*);

   logic [23:0] palette [16] = '{
      24'h000000, 24'hcd3131, 24'h0dbc79, 24'he5e510,
      24'h2472c8, 24'hbc3fbc, 24'h11a8cd, 24'he5e5e5,
      24'h666666, 24'hf14c4c, 24'h23d18b, 24'hf5f543,
      24'h3b8eea, 24'hd670d6, 24'h29b8db, 24'hffffff};
   int cube [6] = '{0, 95, 135, 175, 215, 255};

   pmode_type   pmode;
   logic [11:0] parts [asgr_pkg::MaxParams];
   int          nparts;
   logic [11:0] cur_part;
   logic        a_bold, a_italic, a_uline, fg_on, bg_on;
   logic [23:0] fg_rgb, bg_rgb;

   cell_attr_type pending_cells [$];
   bit          failed;
   bit          calm;
   int          sent;
   int          cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [23:0] xterm_rgb(int idx);
      int c, g;
      if (idx < 16) return palette[idx];
      if (idx < 232) begin
         c = idx - 16;
         return {8'(cube[c / 36]), 8'(cube[(c / 6) % 6]), 8'(cube[c % 6])};
      end
      g = 8 + (idx - 232) * 10;
      return {8'(g), 8'(g), 8'(g)};
   endfunction

   function automatic bit part_good(logic [11:0] p);
      return (p & (EmptyBit | BadBit)) == 0;
   endfunction

   function automatic void paint(bit fg, logic [23:0] rgb);
      if (fg) begin
         fg_on = 1'b1;
         fg_rgb = rgb;
      end else begin
         bg_on = 1'b1;
         bg_rgb = rgb;
      end
   endfunction

   function automatic void store_part();
      if (nparts < asgr_pkg::MaxParams) begin
         parts[nparts] = cur_part;
         nparts++;
      end
      cur_part = EmptyBit;
   endfunction

   function automatic void apply_attrs();
      int i, code, mode;
      bit fg;
      logic [11:0] p, r, g, b;
      for (i = 0; i < nparts; i++) begin
         p = parts[i];
         if (p[11]) continue;
         code = p[10] ? 0 : int'(p[9:0]);
         if (code == 0) begin
            {a_bold, a_italic, a_uline, fg_on, bg_on} = '0;
            fg_rgb = '0;
            bg_rgb = '0;
         end else if (code == 1) a_bold = 1'b1;
         else if (code == 3) a_italic = 1'b1;
         else if (code == 4) a_uline = 1'b1;
         else if (code == 22) a_bold = 1'b0;
         else if (code == 23) a_italic = 1'b0;
         else if (code == 24) a_uline = 1'b0;
         else if (code >= 30 && code <= 37) paint(1, palette[code - 30]);
         else if (code == 39) begin
            fg_on = 1'b0;
            fg_rgb = '0;
         end else if (code >= 40 && code <= 47) paint(0, palette[code - 40]);
         else if (code == 49) begin
            bg_on = 1'b0;
            bg_rgb = '0;
         end else if (code >= 90 && code <= 97) paint(1, palette[code - 82]);
         else if (code >= 100 && code <= 107) paint(0, palette[code - 92]);
         else if ((code == 38 || code == 48) && i + 1 < nparts) begin
            fg = (code == 38);
            i++;
            mode = int'(parts[i][9:0]);
            if (part_good(parts[i]) && mode == 5 && i + 1 < nparts) begin
               i++;
               if (part_good(parts[i]) && parts[i][9:0] <= 255)
                  paint(fg, xterm_rgb(int'(parts[i][9:0])));
            end else if (part_good(parts[i]) && mode == 2 && i + 3 < nparts) begin
               r = parts[i + 1];
               g = parts[i + 2];
               b = parts[i + 3];
               i += 3;
               if (part_good(r) && part_good(g) && part_good(b) && r[9:0] <= 255
                   && g[9:0] <= 255 && b[9:0] <= 255)
                  paint(fg, {r[7:0], g[7:0], b[7:0]});
            end
         end
      end
   endfunction

   function automatic bit predict_cell(logic [15:0] c, output cell_attr_type e);
      int v;
      e = '0;
      if (pmode == PM_CSI) begin
         if (c >= asgr_pkg::FinalLo && c <= asgr_pkg::FinalHi) begin
            store_part();
            if (c == asgr_pkg::MCode) apply_attrs();
            pmode = PM_GROUND;
         end else if (c == asgr_pkg::SemiCode) begin
            store_part();
         end else if (c >= asgr_pkg::ZeroCode && c <= asgr_pkg::NineCode) begin
            v = cur_part[10] ? 0 : int'(cur_part[9:0]);
            v = v * 10 + int'(c - asgr_pkg::ZeroCode);
            if (v > 1023) v = 1023;
            cur_part = (cur_part & BadBit) | 12'(v);
         end else begin
            cur_part = (cur_part & 12'h3ff) | BadBit;
         end
         return 0;
      end
      if (c == asgr_pkg::EscCode) begin
         pmode = PM_ESC;
         return 0;
      end
      if (pmode == PM_ESC && c == asgr_pkg::BrktCode) begin
         pmode = PM_CSI;
         nparts = 0;
         cur_part = EmptyBit;
         return 0;
      end
      pmode = PM_GROUND;
      e.ch = c;
      e.bold = a_bold;
      e.italic = a_italic;
      e.uline = a_uline;
      e.fg_on = fg_on;
      if (fg_on) {e.fg_r, e.fg_g, e.fg_b} = fg_rgb;
      e.bg_on = bg_on;
      if (bg_on) {e.bg_r, e.bg_g, e.bg_b} = bg_rgb;
      return 1;
   endfunction

   task automatic send_char(logic [15:0] c, bit typed = 0, cell_attr_type want = '0);
      cell_attr_type e;
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (predict_cell(c, e)) pending_cells.push_back(typed ? want : e);
   endtask

   task automatic send_number(int v);
      string s;
      int k;
      s = $sformatf("%0d", v);
      for (k = 0; k < s.len(); k++) send_char(16'(s[k]));
   endtask

   task automatic send_sgr_sequence();
      int n, k, pick;
      int codes [] = '{0, 1, 3, 4, 22, 23, 24, 39, 49, 38, 48, 38, 48, 5, 2};
      logic [15:0] junk [] = '{16'h20, 16'h3a, 16'h3f, asgr_pkg::EscCode, 16'h7f, 16'hffff};
      send_char(asgr_pkg::EscCode);
      send_char(asgr_pkg::BrktCode);
      n = $urandom_range(19);
      for (k = 0; k < n; k++) begin
         if (k != 0) send_char(asgr_pkg::SemiCode);
         pick = $urandom_range(99);
         if (pick < 35) send_number(codes[$urandom_range(codes.size() - 1)]);
         else if (pick < 55) send_number($urandom_range(7) + 10 * (3 + $urandom_range(1)));
         else if (pick < 65) send_number($urandom_range(7) + 90 + 10 * $urandom_range(1));
         else if (pick < 85) send_number($urandom_range(255));
         else if (pick < 90) send_number($urandom_range(99999));
         else if (pick < 95) begin
            send_number($urandom_range(9));
            send_char(junk[$urandom_range(junk.size() - 1)]);
         end
      end
      pick = $urandom_range(99);
      if (pick < 85) send_char(asgr_pkg::MCode);
      else if (pick < 92) send_char(asgr_pkg::BrktCode);
      else send_char(16'($urandom_range(asgr_pkg::FinalHi, asgr_pkg::FinalLo)));
   endtask

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      cell_attr_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ch = rsp_tdata[15:0];
         {got.uline, got.italic, got.bold} = rsp_tdata[18:16];
         got.fg_on = rsp_tdata[19];
         got.fg_r = rsp_tdata[27:20];
         got.fg_g = rsp_tdata[35:28];
         got.fg_b = rsp_tdata[43:36];
         got.bg_on = rsp_tdata[44];
         got.bg_r = rsp_tdata[52:45];
         got.bg_g = rsp_tdata[60:53];
         got.bg_b = rsp_tdata[68:61];
         if (pending_cells.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $time, got);
            failed = 1'b1;
         end else begin
            want = pending_cells.pop_front();
            if (got !== want) begin
               $display("%0t: expected %h, actual %h", $time, want, got);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("ansi_sgr_stream_parser: mismatch");
         $finish;
      end
   end

   initial begin
      dir_row_type rows [$];
      cell_attr_type zero_cell;
      string txt;
      int k;
      failed = 1'b0;
      calm = 1'b0;
      sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      pmode = PM_GROUND;
      nparts = 0;
      cur_part = EmptyBit;
      {a_bold, a_italic, a_uline, fg_on, bg_on} = '0;
      fg_rgb = '0;
      bg_rgb = '0;
      zero_cell = '0;

      rows.push_back('{16'h0041, 1, '{ch: 16'h0041, default: '0}});
      rows.push_back('{16'hffff, 1, '{ch: 16'hffff, default: '0}});
      rows.push_back('{16'h0000, 1, zero_cell});
      txt = "\033[1;3;4mx\033[38;5;200;48;2;1;2;3my\033[9999;38;2;7m";
      for (k = 0; k < txt.len(); k++) rows.push_back('{16'(txt[k]), 0, zero_cell});
      rows.push_back('{asgr_pkg::EscCode, 0, zero_cell});
      rows.push_back('{asgr_pkg::BrktCode, 0, zero_cell});
      rows.push_back('{asgr_pkg::MCode, 0, zero_cell});
      rows.push_back('{16'h0071, 1, '{ch: 16'h0071, default: '0}});
      rows.push_back('{asgr_pkg::EscCode, 0, zero_cell});
      rows.push_back('{16'h0051, 1, '{ch: 16'h0051, default: '0}});
      txt = "\033\033[;a1[w\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;1m.\033[m";
      for (k = 0; k < txt.len(); k++) rows.push_back('{16'(txt[k]), 0, zero_cell});

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_char(rows[i].code, rows[i].typed, rows[i].want);

      while (sent < 1500) begin
         calm = (sent > 700 && sent < 950);
         k = $urandom_range(99);
         if (k < 45) send_sgr_sequence();
         else if (k < 85) repeat ($urandom_range(6, 1)) send_char(16'($urandom_range(126, 32)));
         else if (k < 93) send_char(16'($urandom));
         else if (k < 97) send_char(asgr_pkg::EscCode);
         else send_char(asgr_pkg::BrktCode);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (!failed) begin
         $display("ansi_sgr_stream_parser: match");
      end else begin
         $display("ansi_sgr_stream_parser: mismatch");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/asgr_pkg.sv
rtl/asgr_ram.sv
rtl/asgr_ctrl.sv
rtl/asgr_dp.sv
rtl/ansi_sgr_stream_parser.sv
dv/tb.sv
